### design/fmprs_pkg.sv
package fmprs_pkg;

    localparam int NUM_MOTORS = 4;
    localparam int MI_W       = 2;

    localparam logic [6:0] PWM_TOP    = 7'd100;
    localparam logic [6:0] FULL_LEVEL = 7'd100;
    localparam logic [7:0] SPEED_MAX  = 8'd100;

    // item kinds
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ONE  = 2'd1;
    localparam logic [1:0] MODE_ALL  = 2'd2;

    // motor actions
    localparam logic [2:0] ACT_STOP       = 3'd0;
    localparam logic [2:0] ACT_STEP_FWD   = 3'd3;
    localparam logic [2:0] ACT_STEP_BACK  = 3'd4;
    localparam logic [2:0] ACT_STEP_RIGHT = 3'd5;
    localparam logic [2:0] ACT_STEP_LEFT  = 3'd6;

    // ramp phases
    localparam logic [1:0] PH_DOWN = 2'd0;
    localparam logic [1:0] PH_UP   = 2'd1;
    localparam logic [1:0] PH_STEP = 2'd2;

    typedef struct packed {
        logic [1:0]      mode;
        logic [MI_W-1:0] motor_index;
        logic [2:0]      action_code;
        logic [7:0]      speed;
        logic [7:0]      step_count;
    } t_in_item;

    typedef struct packed {
        logic [NUM_MOTORS-1:0] forward_pins;
        logic [NUM_MOTORS-1:0] backward_pins;
        logic                  busy_res;
        logic [NUM_MOTORS-1:0] done_mask;
    } t_out_item;

    // per-motor control for one accepted item
    typedef struct packed {
        logic       tick;   // tick below the period top
        logic       top;    // tick at the period top
        logic       cmd;    // command addressed to this motor
        logic [2:0] act;
        logic [7:0] spd;
        logic [7:0] cnt;
    } t_motor_ctl;

    // per-motor status after the item
    typedef struct packed {
        logic fwd;
        logic back;
        logic done;
    } t_motor_sts;

endpackage

### design/fmprs_if.sv
interface fmprs_in_if import fmprs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fmprs_out_if import fmprs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/four_motor_pwm_ramp_stepper_unit.sv
// Four-channel PWM stepper with a pulsed ramp. Each transfer in is a PWM tick,
// a command for one motor, or a command for all motors; each produces exactly
// one result, presented in the cycle after the input transfer from an output
// register. One item is taken every clock cycle: all four channels update in
// parallel with a compare and an increment each, and the input stays ready
// while the output register is empty or being drained, so the output handshake
// alone sets the rate. The PWM period is 101 ticks; pins clear on the top tick.
module four_motor_pwm_ramp_stepper_unit import fmprs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fmprs_in_if.sink  i_in,
    fmprs_out_if.source o_out
);

    logic       in_xfer;
    logic [6:0] r_pwm_count, n_pwm_count;
    logic       r_busy, n_busy;
    logic       r_out_valid;
    t_out_item  r_out;
    t_in_item   item;
    logic       is_tick, is_top;

    t_motor_ctl            motor_ctl [NUM_MOTORS];
    t_motor_sts            motor_sts [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] fwd_vec, back_vec, done_vec, cmd_vec;

    assign item     = i_in.data;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer  = i_in.valid && i_in.ready;

    assign is_tick = in_xfer && (item.mode == MODE_TICK) && (r_pwm_count < PWM_TOP);
    assign is_top  = in_xfer && (item.mode == MODE_TICK) && !(r_pwm_count < PWM_TOP);

    for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_motor
        logic [7:0] spd_m;

        always_comb begin
            spd_m = item.speed;
            // split speed between even and odd motors on all-motor turn commands
            if (item.action_code == ACT_STEP_RIGHT && (m % 2) == 1) spd_m = '0;
            else if (item.action_code == ACT_STEP_LEFT && (m % 2) == 0) spd_m = '0;
        end

        assign cmd_vec[m] = in_xfer &&
            ((item.mode == MODE_ALL) ||
             (item.mode == MODE_ONE && item.motor_index == MI_W'(m)));

        assign motor_ctl[m].tick = is_tick;
        assign motor_ctl[m].top  = is_top;
        assign motor_ctl[m].cmd  = cmd_vec[m];
        assign motor_ctl[m].act  = item.action_code;
        assign motor_ctl[m].spd  = (item.mode == MODE_ALL) ? spd_m : item.speed;
        assign motor_ctl[m].cnt  = item.step_count;

        fmprs_motor u_motor (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (motor_ctl[m]),
            .i_pwm_count (r_pwm_count),
            .o_sts       (motor_sts[m])
        );

        assign fwd_vec[m]  = motor_sts[m].fwd;
        assign back_vec[m] = motor_sts[m].back;
        assign done_vec[m] = motor_sts[m].done;
    end

    always_comb begin
        n_pwm_count = r_pwm_count;
        n_busy      = r_busy;
        if (is_tick) n_pwm_count = r_pwm_count + 7'd1;
        if (is_top) begin
            n_pwm_count = '0;
            if (|done_vec) n_busy = 1'b0;
        end
        if (|cmd_vec) n_busy = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_count <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pwm_count <= n_pwm_count;
            r_busy      <= n_busy;
            if (in_xfer)          r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out.forward_pins  <= fwd_vec;
            r_out.backward_pins <= back_vec;
            r_out.busy_res      <= n_busy;
            r_out.done_mask     <= done_vec;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

### design/fmprs_motor.sv
module fmprs_motor import fmprs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_motor_ctl i_ctl,
    input  logic [6:0] i_pwm_count,
    output t_motor_sts o_sts
);

    logic [6:0] r_level,  n_level;
    logic [6:0] r_target, n_target;
    logic [7:0] r_steps,  n_steps;
    logic [1:0] r_phase,  n_phase;
    logic [2:0] r_act,    n_act;
    logic       r_idle,   n_idle;
    logic       r_fwd,    n_fwd;
    logic       r_back,   n_back;
    logic       n_done;

    always_comb begin
        n_level  = r_level;
        n_target = r_target;
        n_steps  = r_steps;
        n_phase  = r_phase;
        n_act    = r_act;
        n_idle   = r_idle;
        n_fwd    = r_fwd;
        n_back   = r_back;
        n_done   = 1'b0;

        if (i_ctl.cmd) begin
            n_act = (i_ctl.act <= ACT_STEP_LEFT) ? i_ctl.act : ACT_STOP;
            if (i_ctl.spd > SPEED_MAX) begin
                n_level = '0;
            end else begin
                n_level  = FULL_LEVEL;
                n_target = FULL_LEVEL - i_ctl.spd[6:0];
            end
            n_steps = i_ctl.cnt;
            n_phase = PH_DOWN;
            n_idle  = (i_ctl.spd == 8'd0);
        end else if (i_ctl.tick) begin
            if (r_level == i_pwm_count) begin
                if (r_act == ACT_STEP_BACK) begin
                    n_fwd  = 1'b0;
                    n_back = 1'b1;
                end else if (r_act == ACT_STEP_FWD || r_act == ACT_STEP_RIGHT ||
                             r_act == ACT_STEP_LEFT) begin
                    n_fwd  = 1'b1;
                    n_back = 1'b0;
                end
            end
        end else if (i_ctl.top) begin
            n_fwd  = 1'b0;
            n_back = 1'b0;
            if (!r_idle) begin
                case (r_phase)
                    PH_DOWN: begin
                        if (r_target < r_level) n_level = r_level - 7'd1;
                        else                    n_phase = PH_UP;
                    end
                    PH_UP: begin
                        if (r_level < FULL_LEVEL) n_level = r_level + 7'd1;
                        else                      n_phase = PH_STEP;
                    end
                    PH_STEP: begin
                        if (r_steps > 8'd1) begin
                            n_steps = r_steps - 8'd1;
                        end else begin
                            n_target = FULL_LEVEL;
                            n_done   = 1'b1;
                        end
                        n_phase = PH_DOWN;
                    end
                    default: begin
                        // unused phase: hold
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_target <= FULL_LEVEL;
            r_steps  <= '0;
            r_phase  <= PH_DOWN;
            r_act    <= ACT_STOP;
            r_idle   <= 1'b0;
            r_fwd    <= 1'b0;
            r_back   <= 1'b0;
        end else begin
            r_level  <= n_level;
            r_target <= n_target;
            r_steps  <= n_steps;
            r_phase  <= n_phase;
            r_act    <= n_act;
            r_idle   <= n_idle;
            r_fwd    <= n_fwd;
            r_back   <= n_back;
        end
    end

    assign o_sts.fwd  = n_fwd;
    assign o_sts.back = n_back;
    assign o_sts.done = n_done;

endmodule
